// ===== rtl/core/sctd_pkg.sv =====
// Shared types, constants and the speed table of the serial-to-CAN deframer.
`timescale 1ns / 1ps
`default_nettype none
package sctd_pkg;

    localparam int FRAME_LEN = 20;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;

    localparam logic [7:0] SOF_BYTE    = 8'hAA;
    localparam logic [7:0] EOF_BYTE    = 8'h55;
    localparam logic [1:0] VAR_TAG     = 2'b11;
    localparam logic [7:0] FIXED_DATA  = 8'h01;
    localparam logic [7:0] IDT_STD     = 8'h01;
    localparam logic [7:0] IDT_EXT     = 8'h02;
    localparam logic [7:0] FRM_A       = 8'h01;
    localparam logic [7:0] FRM_B       = 8'h02;
    localparam logic [3:0] FMT_FIXED   = 4'h0;
    localparam logic [3:0] FMT_VAR     = 4'h1;
    localparam logic [3:0] SET_TABLE   = 4'h2;
    localparam logic [3:0] SET_MANUAL  = 4'h3;
    localparam logic [3:0] MAX_DLC     = 4'd8;

    localparam logic [1:0] REPLY_NONE  = 2'd0;
    localparam logic [1:0] REPLY_FIXED = 2'd1;
    localparam logic [1:0] REPLY_VAR   = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_TIMING = 1'b1;

    localparam logic [15:0] RST_PRESCALER = 16'd9;
    localparam logic [4:0]  RST_SEG1      = 5'd3;
    localparam logic [3:0]  RST_SEG2      = 4'd4;

    typedef logic [FRAME_LEN-1:0][7:0] frame_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_end;
    } in_t;

    typedef struct packed {
        logic        kind;
        logic        extended;
        logic [28:0] can_id;
        logic [3:0]  dlc;
        logic [63:0] payload;
        logic [15:0] prescaler;
        logic [4:0]  seg1_quanta;
        logic [3:0]  seg2_quanta;
        logic [1:0]  reply_format;
    } out_t;

    // One finished burst as handed from the front to the back.
    typedef struct packed {
        frame_t     bytes;
        logic [4:0] count;
        logic [7:0] sum;
    } burst_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] prescaler;
        logic [4:0]  seg1;
        logic [3:0]  seg2;
    } timing_t;

    function automatic timing_t speed_lookup(input logic [7:0] code);
        timing_t t;
        t.hit = 1'b1;
        unique case (code)
            8'd1:    begin t.prescaler = 16'd9;   t.seg1 = 5'd2;  t.seg2 = 4'd1; end
            8'd2:    begin t.prescaler = 16'd9;   t.seg1 = 5'd3;  t.seg2 = 4'd1; end
            8'd3:    begin t.prescaler = 16'd9;   t.seg1 = 5'd3;  t.seg2 = 4'd4; end
            8'd4:    begin t.prescaler = 16'd9;   t.seg1 = 5'd3;  t.seg2 = 4'd6; end
            8'd5:    begin t.prescaler = 16'd9;   t.seg1 = 5'd11; t.seg2 = 4'd4; end
            8'd6:    begin t.prescaler = 16'd9;   t.seg1 = 5'd15; t.seg2 = 4'd4; end
            8'd7:    begin t.prescaler = 16'd16;  t.seg1 = 5'd16; t.seg2 = 4'd1; end
            8'd8:    begin t.prescaler = 16'd15;  t.seg1 = 5'd16; t.seg2 = 4'd7; end
            8'd9:    begin t.prescaler = 16'd30;  t.seg1 = 5'd16; t.seg2 = 4'd7; end
            8'd10:   begin t.prescaler = 16'd72;  t.seg1 = 5'd16; t.seg2 = 4'd8; end
            8'd11:   begin t.prescaler = 16'd144; t.seg1 = 5'd16; t.seg2 = 4'd8; end
            8'd12:   begin t.prescaler = 16'd288; t.seg1 = 5'd16; t.seg2 = 4'd8; end
            default: begin
                t.hit = 1'b0; t.prescaler = 16'd0; t.seg1 = 5'd0; t.seg2 = 4'd0;
            end
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sctd_front.sv =====
// Byte collector: stores the first bytes of a burst and keeps the running checksum.
`timescale 1ns / 1ps
`default_nettype none
module sctd_front import sctd_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   s_valid,
    output logic        s_ready,
    input  wire in_t    s_data,
    output logic        push_valid,
    input  wire logic   push_ready,
    output burst_t      push_data
);

    frame_t     bytes_reg, bytes_next;
    logic [4:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic       take;

    assign s_ready = push_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        bytes_next = bytes_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        if (take && count_reg < 5'(FRAME_LEN)) begin
            // checksum covers bytes two to eighteen
            if (count_reg >= 5'd2 && count_reg <= 5'd18) begin
                sum_next = sum_reg + s_data.rx_byte;
            end
            for (int i = 0; i < FRAME_LEN; i++) begin
                if (count_reg == 5'(i)) begin
                    bytes_next[i] = s_data.rx_byte;
                end
            end
            count_next = count_reg + 5'd1;
        end
    end

    assign push_valid      = take && s_data.burst_end;
    assign push_data.bytes = bytes_next;
    assign push_data.count = count_next;
    assign push_data.sum   = sum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end else if (push_valid) begin
            // start the next burst from a clean store
            bytes_reg <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end else begin
            bytes_reg <= bytes_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sctd_queue.sv =====
// Two-entry queue of finished bursts between collector and decoder.
`timescale 1ns / 1ps
`default_nettype none
module sctd_queue import sctd_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push_valid,
    output logic        push_ready,
    input  wire burst_t push_data,
    output logic        pop_valid,
    input  wire logic   pop_ready,
    output burst_t      pop_data
);

    burst_t                mem [QDEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]     cnt_reg, cnt_next;
    logic                  do_push, do_pop;

    assign push_ready = cnt_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        cnt_next = cnt_reg;
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + QCNT_W'(1);
            2'b01:   cnt_next = cnt_reg - QCNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sctd_back.sv =====
// Burst decoder: classifies a burst, applies bit timing and registers the result.
`timescale 1ns / 1ps
`default_nettype none
module sctd_back import sctd_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   pop_valid,
    output logic        pop_ready,
    input  wire burst_t pop_data,
    output logic        m_valid,
    input  wire logic   m_ready,
    output out_t        m_data
);

    logic [15:0] pre_reg, pre_next;
    logic [4:0]  seg1_reg, seg1_next;
    logic [3:0]  seg2_reg, seg2_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic        m_valid_reg, m_valid_next;
    out_t        out_reg, out_next;

    function automatic logic [63:0] gather(input frame_t b, input logic [4:0] start,
                                           input logic [3:0] n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) begin
                v[8*i +: 8] = b[start + 5'(i)];
            end
        end
        return v;
    endfunction

    frame_t      b;
    logic [4:0]  cnt;
    logic        cfg_ok, var_ok, fix_ok, var_ext, fix_ext, produce;
    logic [3:0]  n_var, set_code;
    logic [4:0]  var_end_idx, var_min_len;
    timing_t     tbl;

    assign b        = pop_data.bytes;
    assign cnt      = pop_data.count;
    assign set_code = b[2][3:0];
    assign n_var    = b[1][3:0];
    assign var_ext  = b[1][5];
    assign tbl      = speed_lookup(b[3]);
    assign fix_ext  = b[3] == IDT_EXT;

    assign var_end_idx = {1'b0, n_var} + (var_ext ? 5'd6 : 5'd4);
    assign var_min_len = var_end_idx + 5'd1;

    assign cfg_ok = cnt == 5'(FRAME_LEN) && b[0] == SOF_BYTE && b[1] == EOF_BYTE
                 && (b[2][7:4] == FMT_VAR || b[2][7:4] == FMT_FIXED)
                 && (b[4] == FRM_A || b[4] == FRM_B)
                 && b[19] == pop_data.sum
                 && (set_code == SET_TABLE || set_code == SET_MANUAL);

    assign var_ok = b[0] == SOF_BYTE && b[1][7:6] == VAR_TAG && n_var <= MAX_DLC
                 && cnt >= var_min_len && b[var_end_idx] == EOF_BYTE;

    assign fix_ok = cnt == 5'(FRAME_LEN) && b[0] == SOF_BYTE && b[1] == EOF_BYTE
                 && b[2] == FIXED_DATA
                 && (b[3] == IDT_STD || b[3] == IDT_EXT)
                 && (b[4] == FRM_A || b[4] == FRM_B)
                 && b[9] <= 8'(MAX_DLC) && b[19] == pop_data.sum;

    assign produce   = cfg_ok || var_ok || fix_ok;
    assign pop_ready = !m_valid_reg || m_ready;

    always_comb begin
        pre_next     = pre_reg;
        seg1_next    = seg1_reg;
        seg2_next    = seg2_reg;
        fmt_next     = fmt_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (pop_valid && pop_ready) begin
            out_next = '0;
            priority if (cfg_ok) begin
                fmt_next = (b[2][7:4] == FMT_VAR) ? REPLY_VAR : REPLY_FIXED;
                if (set_code == SET_MANUAL) begin
                    seg1_next = {1'b0, b[14][3:0]} + 5'd1;
                    seg2_next = {1'b0, b[15][2:0]} + 4'd1;
                    pre_next  = {b[17], b[16]};
                end else if (tbl.hit) begin
                    pre_next  = tbl.prescaler;
                    seg1_next = tbl.seg1;
                    seg2_next = tbl.seg2;
                end
                out_next.kind = KIND_TIMING;
            end else if (var_ok) begin
                out_next.kind     = KIND_DATA;
                out_next.extended = var_ext;
                out_next.can_id   = var_ext ? {b[5][4:0], b[4], b[3], b[2]}
                                            : {18'd0, b[3][2:0], b[2]};
                out_next.dlc      = n_var;
                out_next.payload  = gather(b, var_ext ? 5'd6 : 5'd4, n_var);
            end else if (fix_ok) begin
                out_next.kind     = KIND_DATA;
                out_next.extended = fix_ext;
                out_next.can_id   = fix_ext ? {b[8][4:0], b[7], b[6], b[5]}
                                            : {18'd0, b[6][2:0], b[5]};
                out_next.dlc      = b[9][3:0];
                out_next.payload  = gather(b, 5'd10, b[9][3:0]);
            end else begin
                // nothing recognised: drop the burst
                out_next.kind = KIND_DATA;
            end
            out_next.prescaler    = pre_next;
            out_next.seg1_quanta  = seg1_next;
            out_next.seg2_quanta  = seg2_next;
            out_next.reply_format = fmt_next;
            m_valid_next = produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_reg     <= RST_PRESCALER;
            seg1_reg    <= RST_SEG1;
            seg2_reg    <= RST_SEG2;
            fmt_reg     <= REPLY_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            pre_reg     <= pre_next;
            seg1_reg    <= seg1_next;
            seg2_reg    <= seg2_next;
            fmt_reg     <= fmt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/serial_to_can_frame_deframer.sv =====
// Top level of the serial-to-CAN deframer: collector, burst queue and decoder.
//
// Input channel (s_valid/s_ready/s_data): one serial byte per transfer; burst_end
// marks the last byte before line idle. Only the first 20 bytes of a burst are kept.
// Output channel (m_valid/m_ready/m_data): at most one result per burst, either a
// CAN frame to send (kind 0) or the bit timing just applied (kind 1). Every result
// carries the timing and reply format in force after the decode.
// Throughput: one byte per cycle. The collector takes a byte every cycle while the
// two-entry burst queue has room; the decoder empties one burst per cycle into the
// output register while that register is empty or being read.
// The edge that transfers the burst-end byte writes the queue; the decoder then loads
// the output register from the queue and raises m_valid, once no earlier burst waits
// ahead in the queue and the output register is free.
// Reset clears the byte store, the queue and m_valid (not the output data) and
// restores the timing to prescaler 9, segments 3 and 4, reply format none.
// A stalled receiver holds the result in the output register; up to two further
// bursts wait in the queue, after which s_ready drops until space frees up.
`timescale 1ns / 1ps
`default_nettype none
module serial_to_can_frame_deframer import sctd_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic   push_valid, push_ready, pop_valid, pop_ready;
    burst_t push_data, pop_data;

    sctd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sctd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sctd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

// ===== rtl/core/sctd_checker.sv =====
// Port-level checks for the serial-to-CAN deframer, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module sctd_checker import sctd_pkg::*; (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire in_t  s_data,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_timing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_TIMING |->
            !m_data.extended && m_data.can_id == '0 && m_data.dlc == '0
            && m_data.payload == '0)
        else $error("timing result carries frame fields");

    a_std_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.extended |-> m_data.can_id[28:11] == '0)
        else $error("standard identifier wider than 11 bits");

    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.dlc <= MAX_DLC && m_data.reply_format != 2'd3
            && m_data.seg1_quanta != '0 && m_data.seg1_quanta <= 5'd16
            && m_data.seg2_quanta != '0 && m_data.seg2_quanta <= 4'd8)
        else $error("result field out of range");

endmodule

bind serial_to_can_frame_deframer sctd_checker u_sctd_checker (.*);
`default_nettype wire
